// File: hdl/tdlc_pkg.sv
// Package: codes, drive patterns and lever decode for the train drive lever controller.
package tdlc_pkg;

	typedef logic [1:0]  mode_t;
	typedef logic [2:0]  lever_t;
	typedef logic [12:0] drive_t;
	typedef logic [15:0] count_t;

	localparam mode_t MODE_NORMAL    = 2'd0;
	localparam mode_t MODE_STOP      = 2'd1;
	localparam mode_t MODE_EMERGENCY = 2'd2;

	localparam lever_t LEVER_STRONG_BRAKE = 3'd0;
	localparam lever_t LEVER_MED_BRAKE    = 3'd1;
	localparam lever_t LEVER_MIN_BRAKE    = 3'd2;
	localparam lever_t LEVER_NEUTRAL      = 3'd3;
	localparam lever_t LEVER_MIN_ACCEL    = 3'd4;
	localparam lever_t LEVER_MED_ACCEL    = 3'd5;
	localparam lever_t LEVER_MAX_ACCEL    = 3'd6;

	localparam int unsigned LEVER_PINS = 7;

	localparam count_t LIMIT_RESET = 16'd180;
	localparam count_t COUNT_MAX   = 16'hFFFF;

	localparam drive_t DRIVE_OFF         = 13'h0000;
	localparam drive_t DRIVE_MAX_ACCEL   = 13'h0001;
	localparam drive_t DRIVE_MED_ACCEL   = 13'h0002;
	localparam drive_t DRIVE_MIN_ACCEL   = 13'h0004;
	localparam drive_t DRIVE_NEUTRAL     = 13'h0010;
	localparam drive_t DRIVE_MIN_BRAKE   = 13'h0200;
	localparam drive_t DRIVE_MED_BRAKE   = 13'h0400;
	localparam drive_t DRIVE_STRONG_BRAKE = 13'h0800;
	localparam drive_t DRIVE_EMERGENCY   = 13'h1000;

	function automatic drive_t lever_drive(input lever_t lever);
		drive_t d;
		unique case (lever)
			LEVER_STRONG_BRAKE: d = DRIVE_STRONG_BRAKE;
			LEVER_MED_BRAKE:    d = DRIVE_MED_BRAKE;
			LEVER_MIN_BRAKE:    d = DRIVE_MIN_BRAKE;
			LEVER_NEUTRAL:      d = DRIVE_NEUTRAL;
			LEVER_MIN_ACCEL:    d = DRIVE_MIN_ACCEL;
			LEVER_MED_ACCEL:    d = DRIVE_MED_ACCEL;
			LEVER_MAX_ACCEL:    d = DRIVE_MAX_ACCEL;
			default:            d = DRIVE_NEUTRAL;
		endcase
		return d;
	endfunction

endpackage

// File: hdl/train_drive_lever_controller.sv
// Top level: train drive lever controller, one registered pass per input beat.
// An accepted input beat's result beat is registered and appears in the next cycle.
// One beat per cycle if out_ready allows; the result register is the only stage.
// A waiting result does not block input while out_ready is high in that cycle.
// Reset (arst_n low, asynchronous): normal mode, lever neutral, counter and
// flag cleared, drive all off, limit 180, no result pending.
module train_drive_lever_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  tdlc_pkg::count_t     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [8:0]           port_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tdlc_pkg::drive_t     drive_pins,
	output tdlc_pkg::mode_t      mode,
	output tdlc_pkg::lever_t     lever_code,
	output logic                 overspeed
);
	import tdlc_pkg::*;

	count_t limit_q;
	mode_t  mode_q;
	lever_t lever_q;
	count_t count_q;
	logic   flag_q;
	drive_t drive_q;
	logic   out_valid_q;

	logic                  alarm;
	logic                  stop;
	logic [LEVER_PINS-1:0] pins;
	logic                  multi;
	logic                  any_pin;
	lever_t                pos;
	lever_t                lever_dec;
	mode_t                 mode_d;
	lever_t                lever_d;
	count_t                count_d;
	count_t                count_inc;
	logic                  flag_d;
	drive_t                drive_d;
	logic                  accept;

	assign alarm   = port_in[0];
	assign stop    = port_in[1];
	assign pins    = port_in[8:2];
	assign any_pin = |pins;
	assign multi   = |(pins & (pins - 7'd1));

	always_comb begin
		pos = LEVER_STRONG_BRAKE;
		for (int i = 0; i < LEVER_PINS; i++) begin
			if (pins[i]) begin
				pos = lever_t'(i);
			end
		end
	end

	always_comb begin
		priority if (multi) begin
			lever_dec = LEVER_STRONG_BRAKE;
		end else if (any_pin) begin
			lever_dec = pos;
		end else begin
			lever_dec = lever_q;
		end
	end

	assign count_inc = (count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;

	always_comb begin
		mode_d  = mode_q;
		lever_d = lever_dec;
		count_d = count_q;
		flag_d  = flag_q;
		drive_d = drive_q;
		priority if (alarm) begin
			mode_d  = MODE_EMERGENCY;
			lever_d = LEVER_STRONG_BRAKE;
			drive_d = DRIVE_EMERGENCY;
		end else if (stop) begin
			mode_d  = MODE_STOP;
			drive_d = DRIVE_MED_BRAKE;
		end else if (mode_q == MODE_STOP) begin
			if (lever_dec == LEVER_NEUTRAL) begin
				mode_d  = MODE_NORMAL;
				drive_d = DRIVE_NEUTRAL;
			end
		end else begin
			if (lever_dec == LEVER_MAX_ACCEL) begin
				count_d = count_inc;
				flag_d  = flag_q | (count_inc > limit_q);
			end else begin
				count_d = '0;
				flag_d  = 1'b0;
			end
			drive_d = flag_d ? DRIVE_MED_ACCEL : lever_drive(lever_dec);
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			lever_q     <= LEVER_NEUTRAL;
			count_q     <= '0;
			flag_q      <= 1'b0;
			drive_q     <= DRIVE_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q  <= mode_d;
				lever_q <= lever_d;
				count_q <= count_d;
				flag_q  <= flag_d;
				drive_q <= drive_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign drive_pins = drive_q;
	assign mode       = mode_q;
	assign lever_code = lever_q;
	assign overspeed  = flag_q;

endmodule
